>>> rtl/core/rc_pkg.sv
// rc_pkg: types, constants and helper functions shared by the radix converter.
// Used by rc_ctrl, rc_dp and radix_converter. No dependencies.

package rc_pkg;

   localparam int BASE_W    = 6;
   localparam int CSR_IDX_W = 2;
   localparam int DEC_DIGITS = 10;

   localparam logic [BASE_W-1:0]    BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0]    BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0]    BASE_RESET = 6'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BASE = 2'd1;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
   localparam logic [7:0] CHAR_A_UPPER = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_Z_UPPER = 8'h5A;  // 'Z'
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_Z_LOWER = 8'h7A;  // 'z'

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_DIGIT,
      ST_READ,
      ST_LOAD
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_char;    // fold accepted character into accumulator
      logic div_init;     // load dividend, clear digit count
      logic div_step;     // one restoring division bit
      logic digit_store;  // store remainder, restart division
      logic emit_load;    // load output register with next digit
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_last;   // current step is the last bit of the division
      logic quot_zero;  // quotient is zero
      logic cnt_last;   // digit store is about to fill
      logic rp_zero;    // read pointer at least significant (last emitted) digit
      logic out_free;   // output register can take a beat
   } status_type;

   typedef struct packed {
      logic              ok;
      logic [BASE_W-1:0] value;
   } digit_type;

   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      r = b;
      if (b < BASE_MIN) r = BASE_MIN;
      else if (b > BASE_MAX) r = BASE_MAX;
      return r;
   endfunction

   function automatic digit_type decode_char(input logic [7:0] c);
      digit_type r;
      r.ok    = 1'b1;
      r.value = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r.value = BASE_W'(c - CHAR_ZERO);
      end else if (c >= CHAR_A_UPPER && c <= CHAR_Z_UPPER) begin
         r.value = BASE_W'(c - CHAR_A_UPPER) + BASE_W'(DEC_DIGITS);
      end else if (c >= CHAR_A_LOWER && c <= CHAR_Z_LOWER) begin
         r.value = BASE_W'(c - CHAR_A_LOWER) + BASE_W'(DEC_DIGITS);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [7:0] encode_char(input logic [BASE_W-1:0] d);
      logic [7:0] r;
      if (d < BASE_W'(DEC_DIGITS)) r = CHAR_ZERO + 8'(d);
      else r = CHAR_A_UPPER + 8'(d - BASE_W'(DEC_DIGITS));
      return r;
   endfunction

endpackage

>>> rtl/core/rc_ctrl.sv
// rc_ctrl: sequencing state machine of the radix converter.
// Depends on rc_pkg; drives rc_dp through cmd_type, reads status_type.

module rc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_final_char,
   output logic               req_stall,
   input  rc_pkg::status_type status,
   output rc_pkg::cmd_type    cmd
);
   import rc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.take_char = req_valid;
            if (req_valid && req_final_char) state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            cmd.digit_store = 1'b1;
            if (status.quot_zero || status.cnt_last) state_in = ST_READ;
            else state_in = ST_DIV;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = status.rp_zero ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> rtl/core/rc_dp.sv
// rc_dp: datapath of the radix converter: base registers, Horner accumulator,
// restoring divider, digit store and output register. Depends on rc_pkg.

module rc_dp #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [rc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rc_pkg::BASE_W-1:0]      csr_wdata,
   input  logic [7:0]                     req_digit_char,
   input  rc_pkg::cmd_type                cmd,
   output rc_pkg::status_type             status,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_char,
   output logic                           rsp_out_last,
   output logic                           rsp_bad_digit,
   output logic                           rsp_overflowed
);
   import rc_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int BC_W  = $clog2(VALUE_BITS);
   localparam int MAC_W = VALUE_BITS + BASE_W;

   // configuration
   logic [BASE_W-1:0] src_base_ff, tgt_base_ff;
   logic [BASE_W-1:0] src_base, tgt_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_base_ff <= BASE_RESET;
         tgt_base_ff <= BASE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SOURCE_BASE: src_base_ff <= csr_wdata;
            CSR_TARGET_BASE: tgt_base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign src_base = clamp_base(src_base_ff);
   assign tgt_base = clamp_base(tgt_base_ff);

   // accumulate
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  err_ff, err_in, ovf_ff, ovf_in;
   digit_type             dec;
   logic                  dig_ok;
   logic [MAC_W-1:0]      mac;

   // divider and digit bookkeeping
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [BASE_W-1:0]     rem_ff, rem_in;
   logic [BC_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      rp_ff, rp_in;
   logic [BASE_W:0]       rem_shift;
   logic                  rem_ge;

   assign dec    = decode_char(req_digit_char);
   assign dig_ok = dec.ok && (dec.value < src_base);
   assign mac    = ({{BASE_W{1'b0}}, acc_ff} * MAC_W'(src_base)) + MAC_W'(dec.value);

   assign rem_shift = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign rem_ge    = rem_shift >= {1'b0, tgt_base};

   always_comb begin
      acc_in     = acc_ff;
      err_in     = err_ff;
      ovf_in     = ovf_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      cnt_in     = cnt_ff;
      rp_in      = rp_ff;
      if (cmd.take_char) begin
         if (!dig_ok) begin
            err_in = 1'b1;
         end else begin
            acc_in = mac[VALUE_BITS-1:0];
            if (|mac[MAC_W-1:VALUE_BITS]) ovf_in = 1'b1;
         end
      end
      if (cmd.div_init) begin
         quot_in    = acc_ff;
         acc_in     = '0;
         rem_in     = '0;
         bit_cnt_in = '0;
         cnt_in     = '0;
      end
      if (cmd.div_step) begin
         quot_in    = {quot_ff[VALUE_BITS-2:0], rem_ge};
         rem_in     = rem_ge ? BASE_W'(rem_shift - {1'b0, tgt_base}) : BASE_W'(rem_shift);
         bit_cnt_in = bit_cnt_ff + BC_W'(1);
      end
      if (cmd.digit_store) begin
         cnt_in     = cnt_ff + CNT_W'(1);
         rp_in      = cnt_ff[IDX_W-1:0];
         rem_in     = '0;
         bit_cnt_in = '0;
         // digits left over once the store is full
         if (status.cnt_last && !status.quot_zero) ovf_in = 1'b1;
      end
      if (cmd.emit_load) begin
         rp_in = rp_ff - IDX_W'(1);
         if (status.rp_zero) begin
            err_in = 1'b0;
            ovf_in = 1'b0;
            cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         err_ff <= 1'b0;
         ovf_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         err_ff <= err_in;
         ovf_ff <= ovf_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      rp_ff      <= rp_in;
   end

   // digit store, least significant digit at index 0
   logic [BASE_W-1:0] digit_mem [MAX_DIGITS];
   logic [BASE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.digit_store) digit_mem[cnt_ff[IDX_W-1:0]] <= rem_ff;
      rd_data_ff <= digit_mem[rp_ff];
   end

   // output register
   logic       rsp_valid_ff;
   logic [7:0] out_char_ff;
   logic       out_last_ff, bad_ff, ovf_out_ff;

   assign status.div_last  = bit_cnt_ff == BC_W'(VALUE_BITS - 1);
   assign status.quot_zero = quot_ff == '0;
   assign status.cnt_last  = cnt_ff == CNT_W'(MAX_DIGITS - 1);
   assign status.rp_zero   = rp_ff == '0;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit_load) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_char_ff <= encode_char(rd_data_ff);
         out_last_ff <= status.rp_zero;
         bad_ff      <= err_ff;
         ovf_out_ff  <= ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = out_char_ff;
   assign rsp_out_last   = out_last_ff;
   assign rsp_bad_digit  = bad_ff;
   assign rsp_overflowed = ovf_out_ff;

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> status.out_free)
      else $error("output register overwritten while stalled");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.digit_store |-> (cnt_ff < CNT_W'(MAX_DIGITS)))
      else $error("digit store written past its depth");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < tgt_base))
      else $error("division remainder out of range");

   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && status.rp_zero) |=> (!err_ff && !ovf_ff && cnt_ff == '0))
      else $error("number state not cleared after last digit");
`endif

endmodule

>>> rtl/core/radix_converter.sv
// radix_converter: top level of the ASCII number base converter.
// Depends on rc_pkg, rc_ctrl and rc_dp.

// Characters of one number arrive most significant first, one beat each,
// and are taken one per cycle while the block is idle: each digit is folded
// into a VALUE_BITS accumulator as acc * source_base + digit (wrapping, with a
// sticky overflow flag; an invalid character or a digit not below the base
// only sets bad_digit). The beat carrying final_char starts the conversion,
// and req_stall stays high until every digit has been handed to the output
// register. Conversion runs a restoring divider by target_base, one quotient
// bit per cycle: VALUE_BITS division steps yield each output digit, which is
// then written to the digit store. Each digit is read out through the store's
// registered read port and loaded into the output register; loading waits
// while the result side stalls. The
// digits go out as uppercase ASCII, most significant first, with out_last on
// the final one; a zero value gives a single '0'. At most MAX_DIGITS digits
// are kept: a value that needs more emits its low MAX_DIGITS digits with
// overflowed set. bad_digit and overflowed are the same on every beat of a
// number, and all per-number state clears after its last beat is loaded.
// Base registers below 2 act as 2 and above 36 act as 36; write them only
// while the block is idle.

module radix_converter #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_write,
   input  logic [rc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rc_pkg::BASE_W-1:0]    csr_wdata,
   // character beats
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_digit_char,
   input  logic                         req_final_char,
   // result beats
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_char,
   output logic                         rsp_out_last,
   output logic                         rsp_bad_digit,
   output logic                         rsp_overflowed
);
   import rc_pkg::*;

   cmd_type    cmd;
   status_type status;

   rc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_char (req_final_char),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   rc_dp #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_digit_char (req_digit_char),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_out_last   (rsp_out_last),
      .rsp_bad_digit  (rsp_bad_digit),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule
